// File: hdl/blist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blist_pkg: shared types and constants of the bounded list engine
// Sizes of the ring store, operation and error codes, the memory request
// beat between the controller and the store, and ring pointer helpers.
// ----------------------------------------------------------------------------
package blist_pkg;

   // ring store geometry
   localparam int LIST_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W      = 7;
   localparam int DATA_W     = 32;
   localparam int OP_W       = 3;
   localparam int ERR_W      = 3;

   localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(LIST_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_PTR = ADDR_W'(LIST_DEPTH - 1);

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_REMOVE = 3'd1,
      OP_DROP   = 3'd2,
      OP_ROTATE = 3'd3,
      OP_READ   = 3'd4,
      OP_WRITE  = 3'd5
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 3'd0,
      ERR_FULL  = 3'd1,
      ERR_EMPTY = 3'd2,
      ERR_N     = 3'd3,
      ERR_INDEX = 3'd4
   } err_type;

   // one access beat to the ring store
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // slot of a list position: (head + offset) mod LIST_DEPTH, offset <= LIST_DEPTH
   function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                               input logic [CNT_W-1:0]  offset);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W+1-ADDR_W){1'b0}}, head} + {1'b0, offset};
      if (sum >= (CNT_W+1)'(LIST_DEPTH)) begin
         sum = sum - (CNT_W+1)'(LIST_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // advance a ring pointer by one
   function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + ADDR_W'(1);
   endfunction

endpackage

// File: hdl/blist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blist_mem: ring store of the list
// One write port and one read port, read data registered in the cycle after the request.
// ----------------------------------------------------------------------------
module blist_mem (
   input  logic                             clock,
   input  blist_pkg::mem_req_type           mem_req,
   output logic [blist_pkg::DATA_W-1:0]     rd_data
);

   logic [blist_pkg::DATA_W-1:0] store [blist_pkg::LIST_DEPTH];
   logic [blist_pkg::DATA_W-1:0] rd_data_ff;

   // write the requested slot
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // register the read word
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= store[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/blist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blist_ctrl: operation sequencer of the bounded list engine
// Holds head and count, decodes each command, drives the ring store and
// copies the front words to the tail for a rotation.
// ----------------------------------------------------------------------------
module blist_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [blist_pkg::OP_W-1:0]        req_op,
   input  logic [blist_pkg::DATA_W-1:0]      req_value,
   input  logic [blist_pkg::CNT_W-1:0]       req_amount,
   output logic                              rsp_valid,
   output logic [blist_pkg::DATA_W-1:0]      rsp_read_data,
   output logic [blist_pkg::ERR_W-1:0]       rsp_error,
   output logic [blist_pkg::CNT_W-1:0]       rsp_count,
   output blist_pkg::mem_req_type            mem_req,
   input  logic [blist_pkg::DATA_W-1:0]      mem_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RDWAIT,
      ST_COPY,
      ST_RESP
   } state_type;

   state_type                      state_ff, state_in;
   logic [blist_pkg::ADDR_W-1:0]   head_ff, head_in;
   logic [blist_pkg::CNT_W-1:0]    held_ff, held_in;
   logic [blist_pkg::ADDR_W-1:0]   rp_ff, rp_in;
   logic [blist_pkg::ADDR_W-1:0]   wp_ff, wp_in;
   logic [blist_pkg::CNT_W-1:0]    rd_left_ff, rd_left_in;
   logic [blist_pkg::CNT_W-1:0]    wr_left_ff, wr_left_in;
   logic [blist_pkg::CNT_W-1:0]    shift_ff, shift_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [blist_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [blist_pkg::ERR_W-1:0]    rsp_err_ff, rsp_err_in;

   // decode commands and step the sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      held_in      = held_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      rd_left_in   = rd_left_ff;
      wr_left_in   = wr_left_ff;
      shift_in     = shift_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      mem_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in     = ST_RESP;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_err_in   = blist_pkg::ERR_OK;
               case (req_op)
                  blist_pkg::OP_APPEND: begin
                     if (held_ff == blist_pkg::MAX_CNT) begin
                        rsp_err_in = blist_pkg::ERR_FULL;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = blist_pkg::slot(head_ff, held_ff);
                        mem_req.wdata = req_value;
                        held_in       = held_ff + blist_pkg::CNT_W'(1);
                     end
                  end
                  blist_pkg::OP_REMOVE: begin
                     if (held_ff == '0) begin
                        rsp_err_in = blist_pkg::ERR_EMPTY;
                     end else begin
                        held_in = held_ff - blist_pkg::CNT_W'(1);
                     end
                  end
                  blist_pkg::OP_DROP: begin
                     if (req_amount > held_ff) begin
                        rsp_err_in = blist_pkg::ERR_N;
                     end else begin
                        head_in = blist_pkg::slot(head_ff, req_amount);
                        held_in = held_ff - req_amount;
                     end
                  end
                  blist_pkg::OP_ROTATE: begin
                     if (req_amount > held_ff) begin
                        rsp_err_in = blist_pkg::ERR_N;
                     end else if (req_amount != '0 && req_amount != held_ff) begin
                        // copy the first n words behind the tail, then move head
                        state_in     = ST_COPY;
                        rsp_valid_in = 1'b0;
                        rp_in        = head_ff;
                        wp_in        = blist_pkg::slot(head_ff, held_ff);
                        rd_left_in   = req_amount;
                        wr_left_in   = req_amount;
                        shift_in     = req_amount;
                     end
                  end
                  blist_pkg::OP_READ: begin
                     if (req_amount >= held_ff) begin
                        rsp_err_in = blist_pkg::ERR_INDEX;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = blist_pkg::slot(head_ff, req_amount);
                        state_in      = ST_RDWAIT;
                        rsp_valid_in  = 1'b0;
                     end
                  end
                  blist_pkg::OP_WRITE: begin
                     if (req_amount >= held_ff) begin
                        rsp_err_in = blist_pkg::ERR_INDEX;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = blist_pkg::slot(head_ff, req_amount);
                        mem_req.wdata = req_value;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            // take the registered word
            rsp_data_in  = mem_rd_data;
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_COPY: begin
            // issue reads in list order
            if (rd_left_ff != '0) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = rp_ff;
               rp_in         = blist_pkg::next_ptr(rp_ff);
               rd_left_in    = rd_left_ff - blist_pkg::CNT_W'(1);
               rd_pend_in    = 1'b1;
            end
            // write each returned word behind the tail
            if (rd_pend_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = wp_ff;
               mem_req.wdata = mem_rd_data;
               wp_in         = blist_pkg::next_ptr(wp_ff);
               wr_left_in    = wr_left_ff - blist_pkg::CNT_W'(1);
               if (wr_left_ff == blist_pkg::CNT_W'(1)) begin
                  head_in      = blist_pkg::slot(head_ff, shift_ff);
                  state_in     = ST_RESP;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         held_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         held_ff      <= held_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rp_ff       <= rp_in;
      wp_ff       <= wp_in;
      rd_left_ff  <= rd_left_in;
      wr_left_ff  <= wr_left_in;
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_error     = rsp_err_ff;
   assign rsp_count     = held_ff;

endmodule

// File: hdl/bounded_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_engine_top: bounded list engine
// Ordered list of up to 64 signed words in a ring store with head and count.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low. Its one
// result beat appears on the rsp_ ports for a single cycle with rsp_valid
// high and must be captured then: the receiver cannot stall it. Append,
// remove, drop, write and refused commands pass from idle through the
// response state back to idle; a read also waits in RDWAIT for the
// registered store read. A rotation by n (0 < n < count) copies the first
// n words behind the tail through the single store read and write port,
// one word per cycle. The store is not cleared at reset.
// ----------------------------------------------------------------------------
module bounded_list_engine_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [blist_pkg::OP_W-1:0]     req_op,
   input  logic [blist_pkg::DATA_W-1:0]   req_value,
   input  logic [blist_pkg::CNT_W-1:0]    req_amount,
   output logic                           rsp_valid,
   output logic [blist_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [blist_pkg::ERR_W-1:0]    rsp_error,
   output logic [blist_pkg::CNT_W-1:0]    rsp_count
);

   blist_pkg::mem_req_type         mem_req;
   logic [blist_pkg::DATA_W-1:0]   mem_rd_data;

   // sequence commands
   blist_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_amount    (req_amount),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data),
      .rsp_error     (rsp_error),
      .rsp_count     (rsp_count),
      .mem_req       (mem_req),
      .mem_rd_data   (mem_rd_data)
   );

   // hold the list words
   blist_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule
